>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the command frame parser.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

>>> hdl/scfp_pkg.sv
// Types and constants of the serial command frame parser.
// Used by every module of the block; depends on nothing.
package scfp_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CSUM = 2'd1,
        ST_OVFL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN,
        PH_INSTR,
        PH_COLLECT,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } bphase_t;

    // One finished frame, handed from the parser to the result sequencer.
    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   instruction;
        logic [BYTE_W-1:0]   frame_length;
        logic [BYTE_W-1:0]   count;
        logic                bank;
    } cmd_t;

    // Parameter store write request.
    typedef struct packed {
        logic                en;
        logic                bank;
        logic [BYTE_W-1:0]   idx;
        logic [BYTE_W-1:0]   data;
    } pwr_t;

    // Sequencer has finished the run that read a bank.
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    // Sequencer status, for checking bank ownership.
    typedef struct packed {
        logic active;
        logic bank;
    } bstat_t;

endpackage

>>> hdl/scfp_queue.sv
// Two-entry command queue between the frame parser and the result sequencer.
// Depends on scfp_pkg for the command type.
module scfp_queue
    import scfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t       entry_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push && !full, pop && !empty})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/scfp_front.sv
// Frame parser: takes received bytes, tracks the frame, writes parameters
// into the banked store and queues one command per finished frame.
// Depends on scfp_pkg.
module scfp_front
    import scfp_pkg::*;
#(
    parameter int MAX_PARAMS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    output logic              q_push,
    output cmd_t              q_cmd,
    input  logic              q_full,
    output pwr_t              pwr,
    input  done_t             done
);

    localparam logic [BYTE_W-1:0] MAX_CNT = BYTE_W'(MAX_PARAMS);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] len_reg;
    logic [BYTE_W-1:0] len_next;
    logic [BYTE_W-1:0] instr_reg;
    logic [BYTE_W-1:0] instr_next;
    logic [BYTE_W-1:0] cnt_reg;
    logic [BYTE_W-1:0] cnt_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              bank_reg;
    logic              bank_next;
    logic [1:0]        busy_reg;
    logic [1:0]        busy_next;
    logic              accept;
    logic [BYTE_W:0]   cnt_inc;
    logic [BYTE_W:0]   params_due;

    assign accept     = s_tvalid && s_tready;
    assign cnt_inc    = {1'b0, cnt_reg} + 9'd1;
    assign params_due = {1'b0, len_reg} - 9'd2;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        instr_next = instr_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        q_push     = 1'b0;
        q_cmd      = '{status: ST_OK, instruction: instr_reg, frame_length: len_reg,
                       count: cnt_reg, bank: bank_reg};
        pwr        = '{en: 1'b0, bank: bank_reg, idx: cnt_reg, data: s_tdata};
        s_tready   = 1'b1;

        // Do not overwrite a bank that the sequencer still drains, and do not
        // finish a frame while the queue has no room.
        unique case (phase_reg)
            PH_COLLECT: s_tready = !busy_reg[bank_reg];
            PH_CHECK:   s_tready = !q_full;
            default:    s_tready = 1'b1;
        endcase

        if (done.valid)
        begin
            busy_next[done.bank] = 1'b0;
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (s_tdata == header_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    len_next   = s_tdata;
                    sum_next   = s_tdata;
                    phase_next = PH_INSTR;
                end
                PH_INSTR:
                begin
                    instr_next = s_tdata;
                    sum_next   = sum_reg + s_tdata;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    phase_next = (len_reg > 8'd2) ? PH_COLLECT : PH_CHECK;
                end
                PH_COLLECT:
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        pwr.en = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_next = cnt_inc[BYTE_W-1:0];
                    sum_next = sum_reg + s_tdata;
                    if (cnt_inc >= params_due)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    q_push = 1'b1;
                    if (~sum_reg != s_tdata)
                    begin
                        q_cmd.status = ST_CSUM;
                    end
                    else if (ovf_reg)
                    begin
                        q_cmd.status = ST_OVFL;
                    end
                    else if (cnt_reg != '0)
                    begin
                        // The run reads this bank; the next frame uses the other.
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = ~bank_reg;
                    end
                    phase_next = PH_WAIT;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            header_reg <= 8'hFF;
            len_reg    <= '0;
            instr_reg  <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            bank_reg   <= 1'b0;
            busy_reg   <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg_wr_en)
            begin
                header_reg <= cfg_wr_data;
            end
            len_reg   <= len_next;
            instr_reg <= instr_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

>>> hdl/scfp_back.sv
// Result sequencer: pops frame commands, reads the banked parameter store
// and sends one result per parameter, or a single result.
// Depends on scfp_pkg.
module scfp_back
    import scfp_pkg::*;
#(
    parameter int MAX_PARAMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        q_head,
    input  logic        q_empty,
    output logic        q_pop,
    input  pwr_t        pwr,
    output done_t       done,
    output bstat_t      bstat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    logic [BYTE_W-1:0] mem [0:1][0:MAX_PARAMS-1];

    bphase_t           state_reg;
    bphase_t           state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [BYTE_W-1:0] k_reg;
    logic [BYTE_W-1:0] k_next;
    logic              present_reg;
    logic              present_next;
    logic              last_reg;
    logic              last_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_en;
    logic              rd_bank;
    logic [BYTE_W-1:0] rd_idx;
    logic [BYTE_W:0]   k_after;
    logic [BYTE_W-1:0] param_byte;

    assign k_after    = {1'b0, k_reg} + 9'd2;
    assign param_byte = present_reg ? rd_data_reg : '0;

    assign m_tvalid = (state_reg == B_SEND);
    assign m_tlast  = last_reg;
    // tdata from bit 0: instruction[7:0], frame_length[15:8], param_index[21:16],
    // param_byte[29:22], zero pad. tuser from bit 0: status[1:0], param_present[2].
    assign m_tdata  = {2'd0, param_byte, k_reg[5:0], cmd_reg.frame_length,
                       cmd_reg.instruction};
    assign m_tuser  = {present_reg, cmd_reg.status};

    assign bstat.active = (state_reg != B_IDLE) && present_reg;
    assign bstat.bank   = cmd_reg.bank;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        k_next       = k_reg;
        present_next = present_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_bank      = cmd_reg.bank;
        rd_idx       = k_reg;
        done         = '{valid: 1'b0, bank: cmd_reg.bank};

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    k_next   = '0;
                    if (q_head.status == ST_OK && q_head.count != '0)
                    begin
                        present_next = 1'b1;
                        last_next    = (q_head.count == 8'd1);
                        rd_en        = 1'b1;
                        rd_bank      = q_head.bank;
                        rd_idx       = '0;
                        state_next   = B_READ;
                    end
                    else
                    begin
                        present_next = 1'b0;
                        last_next    = 1'b1;
                        state_next   = B_SEND;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_SEND;
            end
            B_SEND:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        done.valid = present_reg;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 8'd1;
                        rd_en      = 1'b1;
                        rd_idx     = k_reg + 8'd1;
                        last_next  = (k_after == {1'b0, cmd_reg.count});
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            present_reg <= 1'b0;
            last_reg    <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            last_reg    <= last_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (pwr.en)
        begin
            mem[pwr.bank][pwr.idx[IDX_W-1:0]] <= pwr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_bank][rd_idx[IDX_W-1:0]];
        end
    end

endmodule

>>> hdl/serial_command_frame_parser.sv
// Serial command frame parser, top level: front parser, command queue and
// result sequencer. Depends on scfp_pkg and assert_macros.svh.
//
// Takes one received byte per request and looks for frames of the form
// header, length, instruction, length minus two parameters, checksum. The
// parser takes a byte every cycle; it holds off input only while a frame's
// parameter bytes arrive for a store bank whose run is still queued or being
// sent, or when a frame ends while the two-entry command queue is full.
// Parameters are kept in two banks of MAX_PARAMS bytes so one frame can be
// parsed while the previous one drains. Each finished frame gives one result,
// or one result per stored parameter; for each stored parameter the sequencer
// first reads the parameter store and then presents the result. No clearing
// pass runs after reset.
module serial_command_frame_parser
    import scfp_pkg::*;
#(
    parameter int MAX_PARAMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // header_value
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // instruction, frame_length, param_index,
                                       // param_byte
    output logic [2:0]  m_tuser,       // status, param_present
    output logic        m_tlast
);

`include "assert_macros.svh"

    logic   q_push;
    cmd_t   q_cmd;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    cmd_t   q_head;
    pwr_t   pwr;
    done_t  done;
    bstat_t bstat;

    scfp_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_push      (q_push),
        .q_cmd       (q_cmd),
        .q_full      (q_full),
        .pwr         (pwr),
        .done        (done)
    );

    scfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    scfp_back #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pwr      (pwr),
        .done     (done),
        .bstat    (bstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A frame never finishes into a full queue.
    `ASSERT_IMPLIES(a_push_room, clk, rst_n, q_push, !q_full)
    // The parser never writes the bank the sequencer is reading.
    `ASSERT_IMPLIES(a_bank_owner, clk, rst_n, pwr.en, !(bstat.active && (bstat.bank == pwr.bank)))
    // After the last result of a run the sequencer goes back to idle.
    `ASSERT_NEXT(a_run_end, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule
